// File: sv/pgmhp_pkg.sv
// Shared types and constants of the PGM header parser.
`default_nettype none
package pgmhp_pkg;

	// Width of the dimension fields on the result channel.
	localparam int DIM_OUT_W = 16;

	// Bytes the header grammar looks for.
	localparam logic [7:0] BYTE_P     = 8'h50;
	localparam logic [7:0] BYTE_FIVE  = 8'h35;
	localparam logic [7:0] BYTE_HASH  = 8'h23;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;

	// The only maxval the parser accepts.
	localparam logic [8:0] MAXVAL_OK  = 9'd255;
	localparam logic [8:0] MAXVAL_SAT = 9'd511;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PIXEL   = 2'd1,
		KIND_IGNORED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_HEADER_ERR = 2'd1,
		ST_MAXVAL_ERR = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             pixel_value;
		logic                   pixel_last;
		logic [DIM_OUT_W-1:0]   image_width;
		logic [DIM_OUT_W-1:0]   image_height;
		logic                   header_done;
		status_t                status;
	} result_t;

endpackage
`default_nettype wire

// File: sv/pgmhp_stream_if.sv
// Input channel of the PGM header parser: one file byte per request.
`default_nettype none
interface pgmhp_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       file_start;

	modport source (output valid, output stream_byte, output file_start, input ready);
	modport sink   (input valid, input stream_byte, input file_start, output ready);
endinterface
`default_nettype wire

// File: sv/pgmhp_result_if.sv
// Result channel of the PGM header parser: one result per input request.
`default_nettype none
interface pgmhp_result_if;
	import pgmhp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic [7:0]           pixel_value;
	logic                 pixel_last;
	logic [DIM_OUT_W-1:0] image_width;
	logic [DIM_OUT_W-1:0] image_height;
	logic                 header_done;
	logic [1:0]           status;

	modport source (output valid, output kind, output pixel_value, output pixel_last,
		output image_width, output image_height, output header_done, output status,
		input ready);
	modport sink   (input valid, input kind, input pixel_value, input pixel_last,
		input image_width, input image_height, input header_done, input status,
		output ready);
endinterface
`default_nettype wire

// File: sv/pgm_header_parser_unit.sv
// Top level of the streaming binary PGM (P5) header parser.
// This unit takes a binary PGM file one byte per request on the stream channel
// and returns exactly one result per request on the result channel. It checks
// the magic "P5" plus line feed, skips comments that open with '#' at a line
// start, and collects decimal width, height and maxval, each ended by a space,
// line feed, tab or NUL. Once a maxval of 255 is seen it passes width*height
// pixel bytes through and flags the last one. Errors are sticky and reported
// in status until a request with file_start set restarts the parser. Every
// byte is handled by the decode logic between the parser state registers and
// the result register, so a new request is taken in every cycle unless the
// skid register is full, and its result goes to the result register or, while
// that holds a waiting result, the skid register. This two-entry output buffer
// keeps the input open for one more request while a result waits. The pixel
// count comes from a registered width*height product settled before maxval ends.
`default_nettype none
module pgm_header_parser_unit #(
	parameter int DIM_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pgmhp_stream_if.sink     stream,
	pgmhp_result_if.source   result
);
	import pgmhp_pkg::*;

	localparam int ACC_W  = DIM_BITS + 4;
	localparam int PROD_W = 2 * DIM_BITS;

	typedef enum logic [3:0] {
		PH_MAG0, PH_MAG1, PH_MAG2, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
		PH_DATA, PH_DONE, PH_ERROR
	} phase_t;

	// Parser state.
	phase_t              phase_q;
	logic                line_start_q;
	logic                comment_q;
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [8:0]          maxval_q;
	logic [PROD_W-1:0]   pixels_q;
	status_t             status_q;
	logic [PROD_W-1:0]   prod_q;

	// State as seen by the current byte: a restart request acts as a reset.
	phase_t              cur_phase;
	logic                cur_line_start;
	logic                cur_comment;
	logic [DIM_BITS-1:0] cur_width;
	logic [DIM_BITS-1:0] cur_height;
	logic [8:0]          cur_maxval;
	logic [PROD_W-1:0]   cur_pixels;
	status_t             cur_status;

	phase_t              nxt_phase;
	logic                nxt_line_start;
	logic                nxt_comment;
	logic [DIM_BITS-1:0] nxt_width;
	logic [DIM_BITS-1:0] nxt_height;
	logic [8:0]          nxt_maxval;
	logic [PROD_W-1:0]   nxt_pixels;
	status_t             nxt_status;

	logic [7:0]          b;
	logic                is_sep;
	logic                is_digit;
	logic [3:0]          digit;
	logic [DIM_BITS-1:0] dim_sel;
	logic [ACC_W-1:0]    dim_next;
	logic                dim_ovf;
	logic [12:0]         mv_next;
	logic                accept;
	logic                hash_skip;
	result_t             res;
	result_t             res_out;

	assign accept = stream.valid && stream.ready;
	assign b      = stream.stream_byte;

	assign cur_phase      = stream.file_start ? PH_MAG0 : phase_q;
	assign cur_line_start = stream.file_start ? 1'b0 : line_start_q;
	assign cur_comment    = stream.file_start ? 1'b0 : comment_q;
	assign cur_width      = stream.file_start ? '0 : width_q;
	assign cur_height     = stream.file_start ? '0 : height_q;
	assign cur_maxval     = stream.file_start ? '0 : maxval_q;
	assign cur_pixels     = stream.file_start ? '0 : pixels_q;
	assign cur_status     = stream.file_start ? ST_OK : status_q;

	assign is_sep   = (b == BYTE_SPACE) || (b == BYTE_LF) || (b == BYTE_TAB) ||
		(b == BYTE_NUL);
	assign is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
	assign digit    = b[3:0];

	// Decimal accumulate: acc*10 + digit as two shifts and two adds.
	assign dim_sel  = (cur_phase == PH_WIDTH) ? cur_width : cur_height;
	assign dim_next = (ACC_W'(dim_sel) << 3) + (ACC_W'(dim_sel) << 1) + ACC_W'(digit);
	assign dim_ovf  = |dim_next[ACC_W-1:DIM_BITS];
	assign mv_next  = (13'(cur_maxval) << 3) + (13'(cur_maxval) << 1) + 13'(digit);

	always_comb begin
		nxt_phase      = cur_phase;
		nxt_line_start = cur_line_start;
		nxt_comment    = cur_comment;
		nxt_width      = cur_width;
		nxt_height     = cur_height;
		nxt_maxval     = cur_maxval;
		nxt_pixels     = cur_pixels;
		nxt_status     = cur_status;
		hash_skip      = 1'b0;
		res.kind        = KIND_HEADER;
		res.pixel_value = 8'd0;
		res.pixel_last  = 1'b0;
		case (cur_phase)
			PH_MAG0: begin
				if (b == BYTE_P) begin
					nxt_phase = PH_MAG1;
				end else begin
					nxt_phase  = PH_ERROR;
					nxt_status = ST_HEADER_ERR;
				end
			end
			PH_MAG1: begin
				if (b == BYTE_FIVE) begin
					nxt_phase = PH_MAG2;
				end else begin
					nxt_phase  = PH_ERROR;
					nxt_status = ST_HEADER_ERR;
				end
			end
			PH_MAG2: begin
				if (b == BYTE_LF) begin
					nxt_phase      = PH_WIDTH;
					nxt_line_start = 1'b1;
				end else begin
					nxt_phase  = PH_ERROR;
					nxt_status = ST_HEADER_ERR;
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
				// A '#' only opens a comment right at a line start.
				if (cur_line_start) begin
					nxt_line_start = 1'b0;
					if (b == BYTE_HASH) begin
						nxt_comment = 1'b1;
						hash_skip   = 1'b1;
					end
				end
				if (hash_skip) begin
					nxt_comment = 1'b1;
				end else if (cur_comment) begin
					if (b == BYTE_LF) begin
						nxt_comment    = 1'b0;
						nxt_line_start = 1'b1;
					end
				end else if (is_sep) begin
					if (cur_phase == PH_WIDTH) begin
						nxt_phase = PH_HEIGHT;
					end else if (cur_phase == PH_HEIGHT) begin
						nxt_phase = PH_MAXVAL;
					end else if (cur_maxval != MAXVAL_OK) begin
						nxt_phase  = PH_ERROR;
						nxt_status = ST_MAXVAL_ERR;
					end else begin
						nxt_pixels = prod_q;
						nxt_phase  = (prod_q != '0) ? PH_DATA : PH_DONE;
					end
				end else if (!is_digit) begin
					nxt_phase  = PH_ERROR;
					nxt_status = ST_HEADER_ERR;
				end else if (cur_phase == PH_MAXVAL) begin
					nxt_maxval = (mv_next > 13'(MAXVAL_SAT)) ? MAXVAL_SAT : mv_next[8:0];
				end else if (dim_ovf) begin
					nxt_phase  = PH_ERROR;
					nxt_status = ST_OVERFLOW;
				end else if (cur_phase == PH_WIDTH) begin
					nxt_width = dim_next[DIM_BITS-1:0];
				end else begin
					nxt_height = dim_next[DIM_BITS-1:0];
				end
			end
			PH_DATA: begin
				res.kind        = KIND_PIXEL;
				res.pixel_value = b;
				nxt_pixels      = cur_pixels - PROD_W'(1);
				if (cur_pixels == PROD_W'(1)) begin
					res.pixel_last = 1'b1;
					nxt_phase      = PH_DONE;
				end
			end
			default: begin
				res.kind = KIND_IGNORED;
			end
		endcase
		res.image_width  = DIM_OUT_W'(nxt_width);
		res.image_height = DIM_OUT_W'(nxt_height);
		res.header_done  = (nxt_phase == PH_DATA) || (nxt_phase == PH_DONE);
		res.status       = nxt_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAG0;
			line_start_q <= 1'b0;
			comment_q    <= 1'b0;
			width_q      <= '0;
			height_q     <= '0;
			maxval_q     <= '0;
			pixels_q     <= '0;
			status_q     <= ST_OK;
		end else if (accept) begin
			phase_q      <= nxt_phase;
			line_start_q <= nxt_line_start;
			comment_q    <= nxt_comment;
			width_q      <= nxt_width;
			height_q     <= nxt_height;
			maxval_q     <= nxt_maxval;
			pixels_q     <= nxt_pixels;
			status_q     <= nxt_status;
		end
	end

	// The product is registered from the stored dimensions. At least a
	// separator, three maxval digits and another separator lie between the
	// last dimension digit and the point where the product is loaded.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(width_q) * PROD_W'(height_q);
	end

	pgmhp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stream.valid),
		.in_ready  (stream.ready),
		.in_data   (res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_out)
	);

	assign result.kind         = res_out.kind;
	assign result.pixel_value  = res_out.pixel_value;
	assign result.pixel_last   = res_out.pixel_last;
	assign result.image_width  = res_out.image_width;
	assign result.image_height = res_out.image_height;
	assign result.header_done  = res_out.header_done;
	assign result.status       = res_out.status;

	// The error phase is only ever entered together with a nonzero status.
	a_error_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) |-> (status_q != ST_OK))
		else $error("error phase with ok status");

	// The data phase always has at least one pixel request still to come.
	a_data_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (pixels_q != '0))
		else $error("data phase with no pixels left");

	// The input only closes when both output entries hold a result.
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> result.valid)
		else $error("input stalled with empty output buffer");

	// Entering the data phase always loads a nonzero pixel count.
	a_data_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cur_phase != PH_DATA) && (nxt_phase == PH_DATA)) |=>
		(pixels_q != '0))
		else $error("data phase entered with zero pixel count");
endmodule
`default_nettype wire

// File: sv/pgmhp_skid.sv
// Two-entry output buffer: result register plus a skid register.
`default_nettype none
module pgmhp_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  pgmhp_pkg::result_t     in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pgmhp_pkg::result_t     out_data
);
	import pgmhp_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    push;
	logic    main_free;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign main_free = !main_valid_q || out_ready;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			// The skid entry is older than anything arriving, and while it is
			// full nothing can arrive.
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end
endmodule
`default_nettype wire

// File: bench/pgm_parse_checker.sv
// Predicts the PGM header parser's result for every accepted request and checks the result channel.
module pgm_parse_checker #(
	parameter int DIM_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pgmhp_stream_if   stream,
	pgmhp_result_if   result,
	output int        mismatches,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import pgmhp_pkg::*;

	typedef enum logic [3:0] {
		PH_MAGIC_P,
		PH_MAGIC_5,
		PH_MAGIC_LF,
		PH_WIDTH,
		PH_HEIGHT,
		PH_MAXVAL,
		PH_PIXELS,
		PH_END,
		PH_FAILED
	} parse_phase_e;

	localparam logic [31:0] DIM_MAX = (32'd1 << DIM_BITS) - 32'd1;

	parse_phase_e         phase;
	logic                 line_start;
	logic                 in_comment;
	logic [DIM_OUT_W-1:0] width_acc;
	logic [DIM_OUT_W-1:0] height_acc;
	logic [8:0]           maxval_acc;
	logic [31:0]          pixels_left;
	status_t              err;

	result_t awaited_results[$];

	function automatic void clear_parser();
		phase       = PH_MAGIC_P;
		line_start  = 1'b0;
		in_comment  = 1'b0;
		width_acc   = '0;
		height_acc  = '0;
		maxval_acc  = '0;
		pixels_left = '0;
		err         = ST_OK;
	endfunction

	function automatic void stop_parse(status_t code);
		err   = code;
		phase = PH_FAILED;
	endfunction

	// Advances the parser by one file byte and returns the result it produces.
	function automatic result_t parse_byte(logic [7:0] b, logic restart);
		logic [31:0] digit;
		logic [31:0] grown;
		logic        handled;
		result_t     r;
		r = '0;
		r.kind = KIND_HEADER;
		if (restart)
			clear_parser();
		digit = {24'd0, b} - {24'd0, BYTE_ZERO};
		handled = 1'b0;
		case (phase)
			PH_MAGIC_P: begin
				if (b == BYTE_P) phase = PH_MAGIC_5;
				else stop_parse(ST_HEADER_ERR);
			end
			PH_MAGIC_5: begin
				if (b == BYTE_FIVE) phase = PH_MAGIC_LF;
				else stop_parse(ST_HEADER_ERR);
			end
			PH_MAGIC_LF: begin
				if (b == BYTE_LF) begin
					phase = PH_WIDTH;
					line_start = 1'b1;
				end else begin
					stop_parse(ST_HEADER_ERR);
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
				if (line_start) begin
					line_start = 1'b0;
					if (b == BYTE_HASH) begin
						in_comment = 1'b1;
						handled = 1'b1;
					end
				end
				// A comment swallows everything up to and including its line feed.
				if (!handled && in_comment) begin
					if (b == BYTE_LF) begin
						in_comment = 1'b0;
						line_start = 1'b1;
					end
					handled = 1'b1;
				end
				if (!handled) begin
					if (b == BYTE_SPACE || b == BYTE_LF || b == BYTE_TAB || b == BYTE_NUL) begin
						case (phase)
							PH_WIDTH:  phase = PH_HEIGHT;
							PH_HEIGHT: phase = PH_MAXVAL;
							default: begin
								if (maxval_acc != MAXVAL_OK) begin
									stop_parse(ST_MAXVAL_ERR);
								end else begin
									pixels_left = {16'd0, width_acc} * {16'd0, height_acc};
									if (pixels_left != 0) phase = PH_PIXELS;
									else phase = PH_END;
								end
							end
						endcase
					end else if (b < BYTE_ZERO || b > BYTE_NINE) begin
						stop_parse(ST_HEADER_ERR);
					end else if (phase == PH_MAXVAL) begin
						grown = {23'd0, maxval_acc} * 32'd10 + digit;
						maxval_acc = (grown > {23'd0, MAXVAL_SAT}) ? MAXVAL_SAT : grown[8:0];
					end else if (phase == PH_WIDTH) begin
						grown = {16'd0, width_acc} * 32'd10 + digit;
						if (grown > DIM_MAX) stop_parse(ST_OVERFLOW);
						else width_acc = grown[DIM_OUT_W-1:0];
					end else begin
						grown = {16'd0, height_acc} * 32'd10 + digit;
						if (grown > DIM_MAX) stop_parse(ST_OVERFLOW);
						else height_acc = grown[DIM_OUT_W-1:0];
					end
				end
			end
			PH_PIXELS: begin
				r.kind = KIND_PIXEL;
				r.pixel_value = b;
				pixels_left = pixels_left - 32'd1;
				if (pixels_left == 0) begin
					r.pixel_last = 1'b1;
					phase = PH_END;
				end
			end
			default: r.kind = KIND_IGNORED;
		endcase
		r.image_width  = width_acc;
		r.image_height = height_acc;
		r.header_done  = (phase == PH_PIXELS || phase == PH_END);
		r.status       = err;
		return r;
	endfunction

	// Counts every mismatch but keeps the log short on a badly broken block.
	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic compare_result();
		result_t want;
		if (awaited_results.size() == 0) begin
			report("result with no request pending, kind", 32'(result.kind), '0);
		end else begin
			want = awaited_results.pop_front();
			if (result.kind !== want.kind)
				report("kind", 32'(result.kind), 32'(want.kind));
			if (result.pixel_value !== want.pixel_value)
				report("pixel_value", 32'(result.pixel_value), 32'(want.pixel_value));
			if (result.pixel_last !== want.pixel_last)
				report("pixel_last", 32'(result.pixel_last), 32'(want.pixel_last));
			if (result.image_width !== want.image_width)
				report("image_width", 32'(result.image_width), 32'(want.image_width));
			if (result.image_height !== want.image_height)
				report("image_height", 32'(result.image_height), 32'(want.image_height));
			if (result.header_done !== want.header_done)
				report("header_done", 32'(result.header_done), 32'(want.header_done));
			if (result.status !== want.status)
				report("status", 32'(result.status), 32'(want.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready)
				compare_result();
			if (stream.valid && stream.ready)
				awaited_results.push_back(parse_byte(stream.stream_byte, stream.file_start));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// File: bench/tb_pgm_header_parser_unit.sv
// Top of the PGM header parser testbench: clock, reset, file stimulus and the verdict.
module tb_pgm_header_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pgmhp_pkg::*;

	localparam int DIM_BITS    = 16;
	localparam int CLK_PERIOD  = 12;
	localparam int ITEMS       = 1800;
	// Past this many file bytes both sides run without idling.
	localparam int CALM_AFTER  = 1500;
	localparam int HOLD_AT     = 600;
	localparam int DRAIN_AT    = 1100;
	localparam int HOLD_CYCLES = 64;
	// Far above the slowest correct run.
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;

	int mismatches;
	int outstanding;
	int cycles = 0;

	// Knobs set by the main sequence for the request driver and the result-side stall process.
	bit src_idle;
	bit sink_stalls;
	bit long_hold;

	// Bytes of the file that is about to be streamed, and how many belong to its header.
	logic [7:0] file_bytes[$];
	int         hdr_len;
	int         bytes_sent;

	pgmhp_stream_if stream_ch();
	pgmhp_result_if result_ch();

	pgm_header_parser_unit #(
		.DIM_BITS(DIM_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	pgm_parse_checker #(
		.DIM_BITS(DIM_BITS)
	) parse_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_pgm_header_parser_unit failed");
			$finish;
		end
	end

	// The result side. It normally takes every result, drops ready in short random bursts
	// while stalls are enabled, and once holds off for a long counted stretch so that the
	// output buffer fills and the parser has to push back on the request channel.
	always begin
		@(negedge clk);
		if (long_hold) begin
			result_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			result_ch.ready <= 1'b1;
			long_hold = 1'b0;
		end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
			result_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Offers one request at a falling edge and returns at the falling edge after it was
	// taken. Valid stays high between back-to-back requests, so it only drops for a gap.
	task automatic put(logic [7:0] b, logic restart);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		stream_ch.valid       <= 1'b1;
		stream_ch.stream_byte <= b;
		stream_ch.file_start  <= restart;
		@(posedge clk);
		while (!stream_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Streams the prepared file; its first byte carries the restart flag.
	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			put(file_bytes[i], i == 0);
		bytes_sent += file_bytes.size();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			file_bytes.push_back(s[i]);
	endtask

	// Decimal digits of a number, sometimes with a redundant leading zero.
	task automatic add_number(int unsigned v);
		if ($urandom_range(0, 7) == 0)
			file_bytes.push_back(BYTE_ZERO);
		add_text($sformatf("%0d", v));
	endtask

	function automatic logic [7:0] any_sep();
		logic [7:0] s;
		case ($urandom_range(0, 3))
			0: s = BYTE_SPACE;
			1: s = BYTE_LF;
			2: s = BYTE_TAB;
			default: s = BYTE_NUL;
		endcase
		return s;
	endfunction

	// A comment of random text; a line feed inside the text would end it early.
	task automatic add_comment();
		logic [7:0] c;
		file_bytes.push_back(BYTE_HASH);
		repeat ($urandom_range(0, 8)) begin
			c = 8'($urandom_range(0, 255));
			if (c == BYTE_LF)
				c = BYTE_HASH;
			file_bytes.push_back(c);
		end
		file_bytes.push_back(BYTE_LF);
	endtask

	// Magic, optional comments right after it (the only place a line starts), then the
	// three numbers. A zero dimension is sometimes left empty, which the parser reads as 0.
	task automatic build_header(int unsigned w, int unsigned h, int unsigned mx);
		file_bytes.delete();
		add_text("P5\n");
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) add_comment();
		if (w != 0 || $urandom_range(0, 1) == 0)
			add_number(w);
		file_bytes.push_back(any_sep());
		if (h != 0 || $urandom_range(0, 1) == 0)
			add_number(h);
		file_bytes.push_back(any_sep());
		add_number(mx);
		file_bytes.push_back(any_sep());
		hdr_len = file_bytes.size();
	endtask

	task automatic add_random_bytes(int n);
		repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// A valid file: mostly tiny images, now and then an empty one at the widest dimension.
	// Some files are cut short so that the next restart lands in the middle of a file.
	task automatic make_good_file();
		int unsigned w;
		int unsigned h;
		int          cut;
		case ($urandom_range(0, 19))
			0: begin w = 65535; h = 0; end
			1: begin w = 0; h = 65535; end
			2: begin w = 0; h = $urandom_range(0, 6); end
			default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
		endcase
		build_header(w, h, MAXVAL_OK);
		add_random_bytes(w * h);
		add_random_bytes($urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut) file_bytes.pop_back();
		end
	endtask

	// A file with one defect: a corrupted header byte, a wrong or oversized maxval,
	// a dimension past the limit, or a doubled separator that shifts the numbers.
	task automatic make_broken_file();
		int unsigned w;
		int unsigned h;
		int          pos;
		w = $urandom_range(1, 4);
		h = $urandom_range(1, 4);
		case ($urandom_range(0, 3))
			0: begin
				build_header(w, h, MAXVAL_OK);
				pos = $urandom_range(0, hdr_len - 1);
				file_bytes[pos] = 8'($urandom_range(0, 255));
			end
			1: begin
				if ($urandom_range(0, 1) == 0) build_header(w, h, $urandom_range(0, 999));
				else build_header(w, h, $urandom_range(1000, 99999));
			end
			2: begin
				if ($urandom_range(0, 1) == 0) build_header($urandom_range(65536, 999999), h, 255);
				else build_header(w, $urandom_range(65536, 999999), 255);
			end
			default: begin
				build_header(w, h, MAXVAL_OK);
				pos = $urandom_range(3, hdr_len - 1);
				file_bytes.insert(pos, any_sep());
			end
		endcase
		add_random_bytes($urandom_range(0, 4));
	endtask

	initial begin
		bit hold_done;
		bit drain_done;
		int pick;

		arst_n                = 1'b0;
		stream_ch.valid       = 1'b0;
		stream_ch.stream_byte = 8'h00;
		stream_ch.file_start  = 1'b0;
		result_ch.ready       = 1'b0;
		src_idle              = 1'b1;
		sink_stalls           = 1'b1;
		long_hold             = 1'b0;
		hold_done             = 1'b0;
		drain_done            = 1'b0;
		bytes_sent            = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bad first magic byte, then a byte that must be ignored.
		file_bytes.delete();
		add_text("Q");
		file_bytes.push_back(8'hFF);
		send_file();

		// Empty comment, tab and NUL separators, a single pixel, then a byte past the end.
		file_bytes.delete();
		add_text("P5\n#\n1\t1");
		file_bytes.push_back(BYTE_NUL);
		add_text("255 ");
		file_bytes.push_back(8'hAB);
		file_bytes.push_back(8'h00);
		send_file();

		// Empty width and height, then a maxval that saturates and is rejected.
		file_bytes.delete();
		add_text("P5\n\n\n999\t");
		send_file();

		// Width beyond the dimension limit on its fifth digit.
		file_bytes.delete();
		add_text("P5\n70000");
		send_file();

		// A letter where a digit belongs.
		file_bytes.delete();
		add_text("P5\nx");
		send_file();

		while (bytes_sent < ITEMS) begin
			// Idling is switched per file so that long runs without gaps occur as well.
			src_idle    = (bytes_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			sink_stalls = (bytes_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);

			if (!hold_done && bytes_sent >= HOLD_AT) begin
				long_hold = 1'b1;
				hold_done = 1'b1;
			end

			// Let the block drain completely before the next file.
			if (!drain_done && bytes_sent >= DRAIN_AT) begin
				drain_done = 1'b1;
				stream_ch.valid <= 1'b0;
				while (outstanding != 0) @(posedge clk);
				@(negedge clk);
			end

			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				make_good_file();
				send_file();
			end else if (pick < 9) begin
				make_broken_file();
				send_file();
			end else begin
				// Raw noise with random restart flags; not counted as file bytes.
				repeat ($urandom_range(1, 6))
					put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		stream_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_pgm_header_parser_unit passed");
		else
			$display("tb_pgm_header_parser_unit failed");
		$finish;
	end

endmodule
